// ----- design/spq_pkg.sv -----
// shared types for the sorted priority queue: channel beats, opcodes, status codes
// and the command that the top level broadcasts to every cell of the chain
// no dependencies
package spq_pkg;

  // field widths fixed by the channel format
  localparam int unsigned FieldWidth = 16;
  localparam int unsigned ExtWidth   = 32;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // input beat
  typedef struct packed {
    op_e                          operation;
    logic [FieldWidth-1:0]        payload;
    logic signed [FieldWidth-1:0] priority_req;
  } in_beat_t;

  // output beat
  typedef struct packed {
    status_e                      status;
    logic [FieldWidth-1:0]        out_payload;
    logic signed [FieldWidth-1:0] out_priority;
  } out_beat_t;

  // command seen by all cells in one cycle
  typedef struct packed {
    logic load;  // the chain changes this cycle
    logic push;  // insert when set, shift toward the head when clear
  } cmd_t;

endpackage

// ----- design/spq_cell.sv -----
// one slot of the sorted chain: holds a single entry and trades it with its neighbors
// depends on spq_pkg for the command struct
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned PW  = 16,
  parameter int unsigned PRW = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cmd_t           cmd_i,
  // entry being pushed
  input  logic [PW-1:0]  new_pay_i,
  input  logic [PRW-1:0] new_pri_i,
  // neighbor toward the head
  input  logic           prev_keep_i,
  input  logic           prev_valid_i,
  input  logic [PW-1:0]  prev_pay_i,
  input  logic [PRW-1:0] prev_pri_i,
  // neighbor toward the tail
  input  logic           next_valid_i,
  input  logic [PW-1:0]  next_pay_i,
  input  logic [PRW-1:0] next_pri_i,
  // own entry and keep flag
  output logic           keep_o,
  output logic           valid_o,
  output logic [PW-1:0]  pay_o,
  output logic [PRW-1:0] pri_o
);

  logic           valid_q, valid_d;
  logic [PW-1:0]  pay_q, pay_d;
  logic [PRW-1:0] pri_q, pri_d;

  // the new entry goes behind this one when it holds equal or higher priority
  assign keep_o = valid_q && ($signed(pri_q) >= $signed(new_pri_i));

  // pick the next content of the slot
  always_comb begin
    valid_d = valid_q;
    pay_d   = pay_q;
    pri_d   = pri_q;
    if (cmd_i.load) begin
      if (cmd_i.push) begin
        if (!prev_keep_i) begin
          valid_d = prev_valid_i;
          pay_d   = prev_pay_i;
          pri_d   = prev_pri_i;
        end else if (!keep_o) begin
          valid_d = 1'b1;
          pay_d   = new_pay_i;
          pri_d   = new_pri_i;
        end
      end else begin
        valid_d = next_valid_i;
        pay_d   = next_pay_i;
        pri_d   = next_pri_i;
      end
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entry contents
  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
    pri_q <= pri_d;
  end

  assign valid_o = valid_q;
  assign pay_o   = pay_q;
  assign pri_o   = pri_q;

endmodule

// ----- design/sorted_priority_queue_top.sv -----
// Bounded priority queue kept sorted in a chain of DEPTH cells, head in cell zero.
// Input channel: in_valid_i / in_stall_o with beat in_data_i (operation, payload,
// priority_req). Output channel: out_valid_o / out_stall_i with beat out_data_o
// (status, out_payload, out_priority). Every input beat yields exactly one output
// beat. A push lands behind all stored entries of equal or higher priority, so equal
// priorities leave in arrival order; a push to a full queue returns ST_FULL and
// changes nothing. A pop returns the head and every cell moves up one place; a pop
// on an empty queue returns ST_EMPTY.
// The result is registered at the edge that takes the beat.
// Throughput is one beat per cycle while in_stall_o is low; each cell compares its
// priority with the pushed one and takes its own, its neighbor's or the new entry in that same cycle.
// The output register frees every cycle its beat is taken, so a new beat is taken
// while a result leaves. While out_stall_i holds a waiting result, in_stall_o is
// raised and the result holds. Reset empties the queue and drops any pending result;
// no clearing pass is needed.
// depends on spq_pkg and spq_cell
module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH          = 16,
  parameter int unsigned PAYLOAD_WIDTH  = 16,
  parameter int unsigned PRIORITY_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam int unsigned PW  = PAYLOAD_WIDTH;
  localparam int unsigned PRW = PRIORITY_WIDTH;

  // chain wires; index zero and DEPTH+1 are the empty ends
  logic           keep_w  [DEPTH+1];
  logic           valid_w [DEPTH+2];
  logic [PW-1:0]  pay_w   [DEPTH+2];
  logic [PRW-1:0] pri_w   [DEPTH+2];

  logic            accept;
  logic            full, empty;
  cmd_t            cmd;
  logic [PW-1:0]   new_pay;
  logic [PRW-1:0]  new_pri;
  logic [ExtWidth-1:0] pay_in_ext, pri_in_ext, head_pay_ext, head_pri_ext;

  logic      out_valid_q, out_valid_d;
  out_beat_t out_q, out_d;

  // input fields cut or zero-extended to the stored widths
  assign pay_in_ext = ExtWidth'(in_data_i.payload);
  assign pri_in_ext = ExtWidth'(unsigned'(in_data_i.priority_req));
  assign new_pay    = pay_in_ext[PW-1:0];
  assign new_pri    = pri_in_ext[PRW-1:0];

  // chain ends
  assign keep_w[0]        = 1'b1;
  assign valid_w[0]       = 1'b0;
  assign pay_w[0]         = '0;
  assign pri_w[0]         = '0;
  assign valid_w[DEPTH+1] = 1'b0;
  assign pay_w[DEPTH+1]   = '0;
  assign pri_w[DEPTH+1]   = '0;

  // handshake and command
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = valid_w[DEPTH];
  assign empty      = !valid_w[1];
  assign cmd.push   = (in_data_i.operation == OP_PUSH);
  assign cmd.load   = accept && (cmd.push ? !full : !empty);

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell #(
      .PW  (PW),
      .PRW (PRW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .new_pay_i    (new_pay),
      .new_pri_i    (new_pri),
      .prev_keep_i  (keep_w[i]),
      .prev_valid_i (valid_w[i]),
      .prev_pay_i   (pay_w[i]),
      .prev_pri_i   (pri_w[i]),
      .next_valid_i (valid_w[i+2]),
      .next_pay_i   (pay_w[i+2]),
      .next_pri_i   (pri_w[i+2]),
      .keep_o       (keep_w[i+1]),
      .valid_o      (valid_w[i+1]),
      .pay_o        (pay_w[i+1]),
      .pri_o        (pri_w[i+1])
    );
  end

  // head entry brought to the output field width, priority sign-extended
  assign head_pay_ext = ExtWidth'(pay_w[1]);
  assign head_pri_ext = ExtWidth'($signed(pri_w[1]));

  // result of the beat being taken
  always_comb begin
    out_d              = out_q;
    out_d.status       = ST_DONE;
    out_d.out_payload  = '0;
    out_d.out_priority = '0;
    out_valid_d        = out_valid_q && out_stall_i;
    if (accept) begin
      out_valid_d = 1'b1;
      if (cmd.push) begin
        if (full) begin
          out_d.status = ST_FULL;
        end
      end else if (empty) begin
        out_d.status = ST_EMPTY;
      end else begin
        out_d.out_payload  = head_pay_ext[FieldWidth-1:0];
        out_d.out_priority = signed'(head_pri_ext[FieldWidth-1:0]);
      end
    end else begin
      out_d = out_q;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output beat
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- test/tb_sorted_priority_queue_top.sv -----
// testbench for sorted_priority_queue_top: directed table then random push/pop traffic,
// every result beat checked against a sorted-queue predictor kept in the bench
// depends on spq_pkg and the design files under design/
`timescale 1ns / 100ps

module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  localparam int QueueDepth  = 16;
  localparam int RandomItems = 1300;
  localparam int HoldCycles  = 60;
  localparam int PrintLimit  = 40;

  // one stored entry of the predicted queue, head at index zero
  typedef struct packed {
    logic [FieldWidth-1:0]        payload;
    logic signed [FieldWidth-1:0] prio;
  } slot_t;

  // one row of the directed stimulus table
  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_data_o;

  slot_t     queue_slots[$];
  out_beat_t expected_beats[$];
  dir_row_t  dir_rows[$];

  int mismatch_count = 0;
  int pushes_stored  = 0;
  int pushes_refused = 0;
  int pops_served    = 0;
  int pops_on_empty  = 0;
  int holds_done     = 0;
  int rx_stall_pct   = 0;
  int tx_idle_pct    = 0;
  int stall_left     = 0;
  bit hold_req       = 1'b0;

  sorted_priority_queue_top #(
    .DEPTH         (QueueDepth),
    .PAYLOAD_WIDTH (FieldWidth),
    .PRIORITY_WIDTH(FieldWidth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // generous run limit
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PrintLimit) $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // sorted queue: insert behind equal or higher priorities, pop from the head
  function automatic out_beat_t apply_to_queue(input in_beat_t b);
    out_beat_t r;
    slot_t     s;
    int        pos;
    r = '0;
    r.status = ST_DONE;
    if (b.operation == OP_PUSH) begin
      if (queue_slots.size() >= QueueDepth) begin
        r.status = ST_FULL;
      end else begin
        s.payload = b.payload;
        s.prio    = b.priority_req;
        pos = 0;
        while (pos < queue_slots.size() && queue_slots[pos].prio >= s.prio) pos++;
        queue_slots.insert(pos, s);
      end
    end else begin
      if (queue_slots.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        s = queue_slots.pop_front();
        r.out_payload  = s.payload;
        r.out_priority = s.prio;
      end
    end
    return r;
  endfunction

  function automatic in_beat_t make_beat(input op_e op, input logic [15:0] pay,
                                         input logic [15:0] pri);
    in_beat_t b;
    b.operation    = op;
    b.payload      = pay;
    b.priority_req = pri;
    return b;
  endfunction

  function automatic out_beat_t make_result(input status_e st, input logic [15:0] pay,
                                            input logic [15:0] pri);
    out_beat_t r;
    r.status       = st;
    r.out_payload  = pay;
    r.out_priority = pri;
    return r;
  endfunction

  function automatic void add_row(input in_beat_t b, input bit typed, input out_beat_t want);
    dir_row_t row;
    row.beat  = b;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // priority shapes: clustered for ties, full range, or the extremes
  function automatic logic [15:0] pick_priority(input int shape);
    int v;
    case (shape)
      0: begin
        v = int'($urandom_range(4)) - 2;
      end
      1: begin
        v = $urandom;
      end
      default: begin
        case ($urandom_range(3))
          0: v = 32'h8000;
          1: v = 32'h7FFF;
          2: v = 0;
          default: v = -1;
        endcase
      end
    endcase
    return v[15:0];
  endfunction

  // drive one input beat at the falling edge and wait until it is taken
  task automatic send_beat(input in_beat_t b, input int gap, input bit typed,
                           input out_beat_t want);
    out_beat_t predicted;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    predicted = apply_to_queue(b);
    expected_beats.push_back(typed ? want : predicted);
    case (predicted.status)
      ST_FULL:  pushes_refused++;
      ST_EMPTY: pops_on_empty++;
      default: begin
        if (b.operation == OP_PUSH) pushes_stored++;
        else pops_served++;
      end
    endcase
  endtask

  // receiver: random stalls plus a long counted hold when asked
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles - 1;
        holds_done++;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(99) < rx_stall_pct) begin
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checker: each taken beat against the oldest expectation
  always @(posedge clk_i) begin : check_results
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing expected", out_data_o));
      end else begin
        want = expected_beats.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data_o.status, want.status));
        if (out_data_o.out_payload !== want.out_payload)
          report_mismatch($sformatf("payload %h, expected %h",
                                    out_data_o.out_payload, want.out_payload));
        if (out_data_o.out_priority !== want.out_priority)
          report_mismatch($sformatf("priority %h, expected %h",
                                    out_data_o.out_priority, want.out_priority));
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int        sent;
    int        seg;
    int        seg_len;
    int        push_pct;
    int        shape;
    op_e       op;
    out_beat_t none;
    none = '0;

    // directed table: empty pop, extremes, equal priorities, fill to full
    add_row(make_beat(OP_POP, 16'h0000, 16'h0000), 1'b1,
            make_result(ST_EMPTY, 16'h0000, 16'h0000));
    add_row(make_beat(OP_PUSH, 16'hFFFF, 16'h7FFF), 1'b0, none);
    add_row(make_beat(OP_PUSH, 16'h0000, 16'h8000), 1'b0, none);
    add_row(make_beat(OP_PUSH, 16'h1234, 16'h0000), 1'b0, none);
    add_row(make_beat(OP_PUSH, 16'h5678, 16'h0000), 1'b0, none);
    add_row(make_beat(OP_POP, 16'hFFFF, 16'hFFFF), 1'b1,
            make_result(ST_DONE, 16'hFFFF, 16'h7FFF));
    add_row(make_beat(OP_POP, 16'h0000, 16'h0000), 1'b0, none);
    for (int i = 0; i < QueueDepth - 2; i++)
      add_row(make_beat(OP_PUSH, ((i % 2) ? 16'hAAAA : 16'h5555) ^ 16'(i),
                        (i % 3 == 0) ? 16'h5555 : (i % 3 == 1) ? 16'hAAAA : 16'(i)),
              1'b0, none);
    add_row(make_beat(OP_PUSH, 16'hFFFF, 16'h7FFF), 1'b1,
            make_result(ST_FULL, 16'h0000, 16'h0000));
    add_row(make_beat(OP_POP, 16'h0000, 16'h0000), 1'b0, none);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, 0, dir_rows[i].typed, dir_rows[i].want);

    // random part in segments with their own push mix, priority shape and idling
    sent = 0;
    seg  = 0;
    while (sent < RandomItems) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(4))
        0: push_pct = 10;
        1: push_pct = 35;
        2: push_pct = 50;
        3: push_pct = 65;
        default: push_pct = 90;
      endcase
      shape = $urandom_range(2);
      case ($urandom_range(2))
        0: tx_idle_pct = 0;
        1: tx_idle_pct = 10;
        default: tx_idle_pct = 40;
      endcase
      case ($urandom_range(2))
        0: rx_stall_pct = 0;
        1: rx_stall_pct = 10;
        default: rx_stall_pct = 40;
      endcase
      // back pressure: long receiver hold while the sender keeps offering beats
      if (seg % 12 == 3) begin
        tx_idle_pct = 0;
        push_pct    = 80;
        hold_req    = 1'b1;
      end
      for (int k = 0; k < seg_len; k++) begin
        op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
        send_beat(make_beat(op, 16'($urandom), pick_priority(shape)),
                  pick_gap(tx_idle_pct), 1'b0, none);
        sent++;
      end
      seg++;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (expected_beats.size() == 0);
    repeat (4) @(posedge clk_i);

    $display("covered %0d stored pushes, %0d refused on full, %0d pops served, %0d pops on empty",
             pushes_stored, pushes_refused, pops_served, pops_on_empty);
    $display("receiver held off for %0d cycles %0d times with the sender still offering beats",
             HoldCycles, holds_done);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue_top.sv
test/tb_sorted_priority_queue_top.sv
